### hw/rtl/tgpg_pkg.sv
// Shared types and constants for the trot gait phase generator.
package tgpg_pkg;

  localparam int PHASE_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int DIV_STEPS  = 16;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;
  localparam int REM_W      = PHASE_W + 1;

  localparam logic [PHASE_W-1:0] HALF_CYCLE   = 24'h800000;
  localparam logic [REM_W-1:0]   FULL_CYCLE   = 25'h1000000;
  localparam logic [15:0]        INV_PERIOD_RST = 16'd512;
  localparam logic [15:0]        DUTY_RST       = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY           = 2'd1;

  typedef struct packed {
    logic        mode;
    logic [15:0] time_step;
  } in_t;

  typedef struct packed {
    logic [15:0] cycle_phase;
    logic        stance_leg0;
    logic        stance_leg1;
    logic        stance_leg2;
    logic        stance_leg3;
    logic [15:0] progress_leg0;
    logic [15:0] progress_leg1;
    logic [15:0] progress_leg2;
    logic [15:0] progress_leg3;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_INIT,
    ST_DIV,
    ST_SAVE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mult;
    logic restart;
    logic accum;
    logic div_init;
    logic div_step;
    logic div_save;
    logic half;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic restart;
  } status_t;

endpackage

### hw/rtl/trot_gait_phase_generator_unit.sv
// Top level of the trot gait phase generator: controller plus datapath.
// Each advance transaction moves a shared Q0.24 gait phase on by time_step
// times inverse_period, wrapping modulo 1.0, and returns one result transaction
// with the top 16 phase bits and, for each of the four legs, a stance flag and
// a Q0.16 progress value. Legs 1 and 3 run with their phase offset by 0.5 from
// legs 0 and 2, so they share results pairwise. The operands are captured at
// the accepting edge, and an advance transaction then runs the 16x16 multiply,
// the accumulate, then two passes of the shared radix-2 restoring divider
// (setup, 16 quotient bits, store), one for the even legs and one for the odd
// legs, and finally loads the output register. A restart transaction clears
// the phase and loads zeros into the output register. The input is ready again
// once the result sits in the output register, even if that result has not yet
// been taken. Configuration writes are always accepted and should be issued
// only while the unit is idle.
module trot_gait_phase_generator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tgpg_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tgpg_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tgpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import tgpg_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // The register file never stalls a configuration transaction.
  assign cfg_ready = 1'b1;

  tgpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tgpg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/tgpg_ctrl.sv
// Controller state machine that sequences the multiply, accumulate and two divisions.
module tgpg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tgpg_pkg::status_t sts,
  output tgpg_pkg::cmd_t    cmd
);
  import tgpg_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             half, half_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      half      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      half      <= half_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    half_next      = half;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.half       = half;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts.restart) begin
          cmd.restart = 1'b1;
          state_next  = ST_RESULT;
        end else begin
          cmd.mult   = 1'b1;
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accum  = 1'b1;
        half_next  = 1'b0;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_SAVE;
        end
      end
      ST_SAVE: begin
        cmd.div_save = 1'b1;
        if (!half) begin
          half_next  = 1'b1;
          state_next = ST_INIT;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/tgpg_datapath.sv
// Datapath: configuration registers, phase accumulator, serial divider and result register.
module tgpg_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  tgpg_pkg::in_t                      in_data,
  input  logic                               cfg_we,
  input  logic [tgpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data,
  input  tgpg_pkg::cmd_t                     cmd,
  output tgpg_pkg::status_t                  sts,
  output tgpg_pkg::out_t                     out_data
);
  import tgpg_pkg::*;

  logic [15:0]        inverse_period;
  logic [15:0]        duty;
  logic [PHASE_W-1:0] phase;
  logic               mode;
  logic [15:0]        time_step;
  logic [31:0]        product;

  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   divisor;
  logic [15:0]        num_lo;
  logic [15:0]        quot;
  logic               stance_cur;

  logic               stance_even, stance_odd;
  logic [15:0]        prog_even, prog_odd;

  logic [PHASE_W-1:0] duty24;
  logic [PHASE_W-1:0] leg_phase;
  logic [REM_W:0]     rem_sh;
  logic               q_bit;

  assign duty24    = {duty, 8'h00};
  assign leg_phase = cmd.half ? (phase + HALF_CYCLE) : phase;
  assign rem_sh    = {rem, num_lo[15]};
  assign q_bit     = (rem_sh >= {1'b0, divisor});
  assign sts.restart = mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_period <= INV_PERIOD_RST;
      duty           <= DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INVERSE_PERIOD: inverse_period <= cfg_data;
        REG_DUTY:           duty           <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.restart) begin
      phase <= '0;
    end else if (cmd.accum) begin
      phase <= phase + product[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode      <= in_data.mode;
      time_step <= in_data.time_step;
    end
    if (cmd.mult) begin
      product <= time_step * inverse_period;
    end

    // Restoring division; the quotient always fits in 16 bits because the
    // upper part of the numerator starts below the divisor.
    if (cmd.div_init) begin
      quot <= '0;
      if (leg_phase < duty24) begin
        stance_cur <= 1'b1;
        rem        <= {9'd0, leg_phase[23:8]};
        num_lo     <= {leg_phase[7:0], 8'h00};
        divisor    <= {9'd0, duty};
      end else begin
        stance_cur <= 1'b0;
        rem        <= {1'b0, leg_phase - duty24};
        num_lo     <= '0;
        divisor    <= FULL_CYCLE - {1'b0, duty24};
      end
    end else if (cmd.div_step) begin
      num_lo <= {num_lo[14:0], 1'b0};
      quot   <= {quot[14:0], q_bit};
      if (q_bit) begin
        rem <= REM_W'(rem_sh - {1'b0, divisor});
      end else begin
        rem <= rem_sh[REM_W-1:0];
      end
    end

    if (cmd.restart) begin
      stance_even <= 1'b0;
      stance_odd  <= 1'b0;
      prog_even   <= '0;
      prog_odd    <= '0;
    end else if (cmd.div_save) begin
      if (cmd.half) begin
        stance_odd <= stance_cur;
        prog_odd   <= quot;
      end else begin
        stance_even <= stance_cur;
        prog_even   <= quot;
      end
    end

    if (cmd.out_load) begin
      out_data.cycle_phase   <= phase[PHASE_W-1:PHASE_W-FRAC_W];
      out_data.stance_leg0   <= stance_even;
      out_data.stance_leg1   <= stance_odd;
      out_data.stance_leg2   <= stance_even;
      out_data.stance_leg3   <= stance_odd;
      out_data.progress_leg0 <= prog_even;
      out_data.progress_leg1 <= prog_odd;
      out_data.progress_leg2 <= prog_even;
      out_data.progress_leg3 <= prog_odd;
    end
  end

endmodule

### test/trot_gait_phase_generator_unit_tb.sv
// Self-checking testbench for the trot gait phase generator unit.
module trot_gait_phase_generator_unit_tb;
  import tgpg_pkg::*;

  // The index field is two bits wide, but only two registers exist. Writes to
  // the spare indexes must leave the configuration untouched.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // An advance transaction runs the multiply, the accumulate, both divider passes
  // and the output load in the unit. The random part has 900 ticks, each with a
  // sender gap and a receiver stall, plus the long receiver hold-off. The limit leaves several times that margin.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BLOCK  = 100;
  localparam int MAX_PRINTED   = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_INVERSE_PERIOD;
  logic [15:0]          cfg_data  = '0;

  trot_gait_phase_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Ticks waiting to be offered, and gait results predicted but not yet seen.
  in_t  tick_q[$];
  out_t gait_expect_q[$];

  // Our own copy of the unit's state and registers.
  logic [PHASE_W-1:0] phase_acc        = '0;
  logic [15:0]        model_inv_period = INV_PERIOD_RST;
  logic [15:0]        model_duty       = DUTY_RST;

  // Set at the rising edge on which an input transaction completed, so the
  // driver knows at the next falling edge that it may present a new tick.
  logic in_fire = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_armed    = 1'b0;
  bit hold_served   = 1'b0;
  int hold_count    = 0;

  int cycle_count    = 0;
  int error_count    = 0;
  int tick_count     = 0;
  int restart_count  = 0;
  int results_seen   = 0;
  int cfg_write_count = 0;

  // Classifies one leg from its offset phase in Q0.24. Returns the stance flag
  // above a Q0.16 progress value. Stance covers the phase below duty, and
  // swing covers the rest of the cycle; each is scaled to a full Q0.16 range.
  function automatic logic [16:0] leg_eval(input logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] duty_q24;
    logic [47:0]        quo;
    logic               in_stance;
    duty_q24 = {model_duty, 8'h00};
    if (p < duty_q24) begin
      // A phase below duty means duty is nonzero, so the divide is safe.
      in_stance = 1'b1;
      quo = {16'h0000, p, 8'h00} / 48'(model_duty);
    end else begin
      // The swing span is one full cycle minus duty, never zero.
      in_stance = 1'b0;
      quo = {8'h00, p - duty_q24, 16'h0000} / (48'h1000000 - 48'(duty_q24));
    end
    return {in_stance, (quo > 48'd65535) ? 16'hFFFF : quo[15:0]};
  endfunction

  // Advances the gait phase for one tick and forms the result it must produce.
  function automatic out_t gait_predict(input in_t tick);
    out_t               res;
    logic [31:0]        inc;
    logic [PHASE_W-1:0] odd_phase;
    res = '0;
    if (tick.mode) begin
      // Restart clears the phase and every reported field.
      phase_acc = '0;
      return res;
    end
    // The increment is exact in Q8.24; whole cycles fall off the top.
    inc       = 32'(tick.time_step) * 32'(model_inv_period);
    phase_acc = phase_acc + inc[PHASE_W-1:0];
    odd_phase = phase_acc + HALF_CYCLE;
    res.cycle_phase = phase_acc[PHASE_W-1:8];
    {res.stance_leg0, res.progress_leg0} = leg_eval(phase_acc);
    {res.stance_leg1, res.progress_leg1} = leg_eval(odd_phase);
    {res.stance_leg2, res.progress_leg2} = leg_eval(phase_acc);
    {res.stance_leg3, res.progress_leg3} = leg_eval(odd_phase);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED)
      $display("[%0t] MISMATCH on result %0d: %s", $time, results_seen, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Sampling side: everything the unit accepts or produces is observed at the
  // rising edge, where the driven inputs have been stable for half a period.
  always @(posedge clk) begin
    out_t want;
    in_fire <= !rst && in_valid && in_ready;
    if (rst) begin
      phase_acc        = '0;
      model_inv_period = INV_PERIOD_RST;
      model_duty       = DUTY_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_write_count++;
        case (cfg_index)
          REG_INVERSE_PERIOD: model_inv_period = cfg_data;
          REG_DUTY:           model_duty       = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        gait_expect_q.push_back(gait_predict(in_data));
        if (in_data.mode) restart_count++;
        else tick_count++;
      end
      if (out_valid && out_ready) begin
        if (gait_expect_q.size() == 0) begin
          report_mismatch("result transaction arrived with nothing expected");
        end else begin
          want = gait_expect_q.pop_front();
          check_field("cycle_phase", out_data.cycle_phase, want.cycle_phase);
          check_field("stance_leg0", 16'(out_data.stance_leg0), 16'(want.stance_leg0));
          check_field("stance_leg1", 16'(out_data.stance_leg1), 16'(want.stance_leg1));
          check_field("stance_leg2", 16'(out_data.stance_leg2), 16'(want.stance_leg2));
          check_field("stance_leg3", 16'(out_data.stance_leg3), 16'(want.stance_leg3));
          check_field("progress_leg0", out_data.progress_leg0, want.progress_leg0);
          check_field("progress_leg1", out_data.progress_leg1, want.progress_leg1);
          check_field("progress_leg2", out_data.progress_leg2, want.progress_leg2);
          check_field("progress_leg3", out_data.progress_leg3, want.progress_leg3);
        end
        results_seen++;
      end
    end
  end

  // Tick driver. A presented tick is held until its transaction completes;
  // only then may the next one go out, possibly after a random gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver. Once armed, it refuses results for a long stretch so the
  // output register fills and the unit has to stall its input side.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_armed && !hold_served) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_served <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[%0t] Timeout after %0d cycles", $time, cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Writes one register. Only called while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued tick has been taken and every result has come
  // back. Every tick yields one result, so the unit is idle after that.
  task automatic drain_ticks();
    while (tick_q.size() != 0 || in_valid || gait_expect_q.size() != 0)
      @(posedge clk);
  endtask

  function automatic in_t make_tick(input logic mode, input logic [15:0] step);
    in_t t;
    t.mode      = mode;
    t.time_step = step;
    return t;
  endfunction

  // Register values lean toward the extremes and the duty reset point.
  function automatic logic [15:0] pick_setting();
    case ($urandom_range(5))
      0:       return 16'd1;
      1:       return 16'd65535;
      2:       return 16'd32768;
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  // Mostly advances with a spread of step sizes; restarts now and then.
  function automatic in_t random_tick();
    logic [15:0] step;
    case ($urandom_range(9))
      0:       step = '0;
      1, 2:    step = 16'($urandom_range(255));
      3:       step = 16'($urandom_range(65535, 65280));
      default: step = 16'($urandom_range(65535));
    endcase
    return make_tick($urandom_range(99) < 8, step);
  endfunction

  initial begin
    int phase_sel;
    int blk;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 7;
    recv_idle_pct = 70;

    // Reset settings: inverse period 512, duty one half, so each unit of
    // step adds 512 to the Q0.24 phase. A restart must ignore its step field.
    tick_q.push_back(make_tick(1'b1, 16'hFFFF));
    tick_q.push_back(make_tick(1'b0, 16'd0));
    tick_q.push_back(make_tick(1'b0, 16'd1));
    tick_q.push_back(make_tick(1'b0, 16'd16384));
    // This one lands the phase exactly on one full cycle, which must read 0.
    tick_q.push_back(make_tick(1'b0, 16'd16383));
    // Largest step: more than one whole cycle, which must be dropped.
    tick_q.push_back(make_tick(1'b0, 16'hFFFF));
    tick_q.push_back(make_tick(1'b1, 16'd0));
    // Exactly half a cycle: even legs sit on the duty boundary, odd legs on 0.
    tick_q.push_back(make_tick(1'b0, 16'd16384));
    tick_q.push_back(make_tick(1'b0, 16'd8192));
    drain_ticks();

    // Fastest gait with the shortest stance; spare indexes must do nothing.
    write_reg(REG_INVERSE_PERIOD, 16'hFFFF);
    write_reg(REG_DUTY, 16'd1);
    write_reg(REG_SPARE_A, 16'h1234);
    write_reg(REG_SPARE_B, 16'hFFFF);
    tick_q.push_back(make_tick(1'b0, 16'hFFFF));
    tick_q.push_back(make_tick(1'b0, 16'd1));
    tick_q.push_back(make_tick(1'b0, 16'd256));
    tick_q.push_back(make_tick(1'b1, 16'h5555));
    tick_q.push_back(make_tick(1'b0, 16'd3));
    drain_ticks();

    // Slowest gait with the longest stance.
    write_reg(REG_INVERSE_PERIOD, 16'd1);
    write_reg(REG_DUTY, 16'hFFFF);
    tick_q.push_back(make_tick(1'b0, 16'hFFFF));
    tick_q.push_back(make_tick(1'b0, 16'd1));
    tick_q.push_back(make_tick(1'b0, 16'd32768));
    tick_q.push_back(make_tick(1'b0, 16'd0));
    drain_ticks();

    // Zero duty: no leg is ever in stance and swing spans the whole cycle.
    write_reg(REG_INVERSE_PERIOD, 16'd256);
    write_reg(REG_DUTY, 16'd0);
    tick_q.push_back(make_tick(1'b0, 16'd100));
    tick_q.push_back(make_tick(1'b0, 16'hFFFF));
    tick_q.push_back(make_tick(1'b0, 16'd32768));
    drain_ticks();

    // Random part in three idling regimes, each split into blocks that run
    // under a fresh pair of register settings. The last regime also carries
    // the long receiver hold-off.
    for (phase_sel = 0; phase_sel < 3; phase_sel++) begin
      case (phase_sel)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_armed    = 1'b1;
        end
      endcase
      for (blk = 0; blk < 3; blk++) begin
        write_reg(REG_INVERSE_PERIOD, pick_setting());
        write_reg(REG_DUTY, pick_setting());
        repeat (RANDOM_BLOCK) tick_q.push_back(random_tick());
        drain_ticks();
      end
    end

    // Give a stray extra result a chance to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d advance and %0d restart transactions.",
             results_seen, tick_count, restart_count);
    $display("Made %0d register writes across three idling regimes and one long hold-off.",
             cfg_write_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
